// File: rtl/fspm_pkg.sv
`timescale 1ns / 1ps
// Package for the frame stream pixel mapper: phase type, magic bytes,
// frame sizes and the pixel hit struct. No dependencies.
package fspm_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SIZE = 2'd1,
        PH_CHAN = 2'd2,
        PH_PIX  = 2'd3
    } t_phase;

    localparam logic [7:0] MAGIC_0 = 8'h23;
    localparam logic [7:0] MAGIC_1 = 8'h54;
    localparam logic [7:0] MAGIC_2 = 8'h26;
    localparam logic [7:0] MAGIC_3 = 8'h66;

    localparam logic [7:0] WIDE_W   = 8'd18;
    localparam logic [7:0] WIDE_H   = 8'd8;
    localparam logic [7:0] SQUARE_W = 8'd16;
    localparam logic [7:0] SQUARE_H = 8'd16;

    localparam int LEVEL_SHIFT = 6;

    typedef struct packed {
        logic       hit;
        logic [3:0] x;
        logic [3:0] y;
    } t_pix_hit;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/frame_stream_pixel_mapper_unit.sv
`timescale 1ns / 1ps
// Top level of the frame stream pixel mapper: frame parser and output register.
// Depends on fspm_pkg and fspm_pixel_map.
//
// The slave stream takes one received byte per beat in s_axis_tdata. The
// parser hunts for the magic 23 54 26 66, reads four size bytes and four
// channel bytes, then maps each pixel byte of an 18x8 or 16x16 frame to a
// display write. Frames larger than MAX_PIXELS are dropped after the size.
// Each write leaves on the master stream as one beat carrying x, y and a
// two-bit level. A write appears in the cycle after the byte that caused it
// is accepted; bytes that cause no write produce no beat.
// One byte is taken every cycle unless a write waits on a stalled receiver.
// The result register holds a write while the receiver stalls; a new byte
// is still accepted when that register is empty or is being emptied in the
// same cycle, so a stall stops the input only while a write is waiting.
// Synchronous active-low reset returns the parser to hunting and empties
// the result register.
module frame_stream_pixel_mapper_unit
    import fspm_pkg::*;
#(
    parameter int MAX_PIXELS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [3:0] pixel_x, [7:4] pixel_y, [9:8] level
);

    localparam int BW = $clog2(MAX_PIXELS + 1);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr, n_hdr;
    logic [7:0]  r_height, n_height;
    logic [7:0]  r_width, n_width;
    logic [BW-1:0] r_left, n_left;
    logic [7:0]  r_col, n_col;
    logic [7:0]  r_row, n_row;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic        w_accept;
    logic [15:0] w_np;
    logic [7:0]  w_col_inc;
    logic        w_emit;
    t_pix_hit    w_hit;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_np          = 16'(s_axis_tdata) * 16'(r_height);
    assign w_col_inc     = r_col + 8'd1;

    fspm_pixel_map u_map (
        .i_frame_height (r_height),
        .i_frame_width  (r_width),
        .i_column       (r_col),
        .i_row          (r_row),
        .o_hit          (w_hit)
    );

    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_height = r_height;
        n_width  = r_width;
        n_left   = r_left;
        n_col    = r_col;
        n_row    = r_row;
        w_emit   = 1'b0;
        if (w_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (s_axis_tdata == magic_byte(r_hdr)) begin
                        n_hdr = r_hdr + 2'd1;
                        if (r_hdr == 2'd3) begin
                            n_phase = PH_SIZE;
                        end
                    end else begin
                        n_hdr = 2'd0;
                    end
                end
                PH_SIZE: begin
                    n_hdr = r_hdr + 2'd1;
                    if (r_hdr == 2'd1) begin
                        n_height = s_axis_tdata;
                    end
                    if (r_hdr == 2'd3) begin
                        n_width = s_axis_tdata;
                        if (w_np > 16'(MAX_PIXELS)) begin
                            n_phase = PH_HUNT;
                        end else begin
                            n_left  = w_np[BW-1:0];
                            n_phase = PH_CHAN;
                        end
                    end
                end
                PH_CHAN: begin
                    n_hdr = r_hdr + 2'd1;
                    if (r_hdr == 2'd3) begin
                        n_col   = 8'd0;
                        n_row   = 8'd0;
                        n_phase = (r_left == '0) ? PH_HUNT : PH_PIX;
                    end
                end
                PH_PIX: begin
                    w_emit = w_hit.hit;
                    if (w_col_inc == r_width) begin
                        n_col = 8'd0;
                        n_row = r_row + 8'd1;
                    end else begin
                        n_col = w_col_inc;
                    end
                    if (r_left != '0) begin
                        n_left = r_left - BW'(1);
                    end
                    if (r_left <= BW'(1)) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_hdr    <= 2'd0;
            r_height <= 8'd0;
            r_width  <= 8'd0;
            r_left   <= '0;
            r_col    <= 8'd0;
            r_row    <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_height <= n_height;
            r_width  <= n_width;
            r_left   <= n_left;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {6'd0, s_axis_tdata[7:LEVEL_SHIFT], w_hit.y, w_hit.x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/fspm_pixel_map.sv
`timescale 1ns / 1ps
// Maps a frame position to a display coordinate for the supported frame sizes.
// Depends on fspm_pkg.
module fspm_pixel_map
    import fspm_pkg::*;
(
    input  logic [7:0] i_frame_height,
    input  logic [7:0] i_frame_width,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    output t_pix_hit   o_hit
);

    logic [7:0] w_x_wide;
    logic [7:0] w_y_wide;
    logic [7:0] w_x_square;

    assign w_x_wide   = 8'd16 - i_column;
    assign w_y_wide   = i_row + 8'd4;
    assign w_x_square = 8'd15 - i_column;

    always_comb begin
        o_hit = '0;
        if (i_frame_height == WIDE_H && i_frame_width == WIDE_W) begin
            if (i_column >= 8'd1 && i_column <= 8'd16 && i_row < 8'd8) begin
                o_hit.hit = 1'b1;
                o_hit.x   = w_x_wide[3:0];
                o_hit.y   = w_y_wide[3:0];
            end
        end else if (i_frame_height == SQUARE_H && i_frame_width == SQUARE_W) begin
            if (i_column < 8'd16 && i_row < 8'd16) begin
                o_hit.hit = 1'b1;
                o_hit.x   = w_x_square[3:0];
                o_hit.y   = i_row[3:0];
            end
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_stream_pixel_mapper_unit: streams frame bytes
// with random gaps and stalls and checks every pixel write beat against its own
// frame parser. Depends on fspm_pkg and the block's RTL.
module tb;
    import fspm_pkg::*;

    localparam int PIXEL_LIMIT = 256;
    localparam int BYTE_TARGET = 1250;
    localparam int QUIET_LIMIT = 5000;
    localparam logic [7:0] MAGIC_SEQ [4] = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};

    typedef struct packed {
        logic [3:0] x;
        logic [3:0] y;
        logic [1:0] level;
    } t_pixel_write;

    class pixel_write_board;
        t_phase         phase = PH_HUNT;
        logic [2:0]     hdr_cnt = '0;
        logic [7:0]     height = '0;
        logic [7:0]     width = '0;
        logic [8:0]     left = '0;
        logic [7:0]     col = '0;
        logic [7:0]     row = '0;
        t_pixel_write   pending_writes[$];
        int             mismatches = 0;

        function void take_byte(logic [7:0] b);
            int np;
            logic hit;
            t_pixel_write w;
            case (phase)
                PH_HUNT: begin
                    if (b == MAGIC_SEQ[hdr_cnt[1:0]]) begin
                        hdr_cnt = hdr_cnt + 3'd1;
                        if (hdr_cnt >= 3'd4) begin
                            hdr_cnt = '0;
                            phase = PH_SIZE;
                        end
                    end else begin
                        hdr_cnt = '0;
                    end
                end
                PH_SIZE: begin
                    if (hdr_cnt == 3'd1) height = b;
                    else if (hdr_cnt == 3'd3) width = b;
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= 3'd4) begin
                        np = int'(width) * int'(height);
                        hdr_cnt = '0;
                        if (np > PIXEL_LIMIT) begin
                            phase = PH_HUNT;
                        end else begin
                            left = 9'(np);
                            phase = PH_CHAN;
                        end
                    end
                end
                PH_CHAN: begin
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= 3'd4) begin
                        hdr_cnt = '0;
                        col = '0;
                        row = '0;
                        phase = (left == '0) ? PH_HUNT : PH_PIX;
                    end
                end
                default: begin
                    hit = 1'b0;
                    w = '0;
                    if (height == WIDE_H && width == WIDE_W) begin
                        if (col >= 8'd1 && col <= 8'd16 && row < 8'd8) begin
                            hit = 1'b1;
                            w.x = 4'(8'd16 - col);
                            w.y = 4'(row + 8'd4);
                        end
                    end else if (height == SQUARE_H && width == SQUARE_W) begin
                        if (col < 8'd16 && row < 8'd16) begin
                            hit = 1'b1;
                            w.x = 4'(8'd15 - col);
                            w.y = 4'(row);
                        end
                    end
                    if (hit) begin
                        w.level = 2'(b >> LEVEL_SHIFT);
                        pending_writes.push_back(w);
                    end
                    col = col + 8'd1;
                    if (col == width) begin
                        col = '0;
                        row = row + 8'd1;
                    end
                    if (left > '0) left = left - 9'd1;
                    if (left == '0) phase = PH_HUNT;
                end
            endcase
        endfunction

        function void check_write(t_pixel_write got);
            t_pixel_write want;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: write beat x=%0d y=%0d level=%0d with none expected",
                             $realtime, got.x, got.y, got.level);
                return;
            end
            want = pending_writes.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.level !== want.level) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: write mismatch, expected x=%0d y=%0d level=%0d,",
                              " got x=%0d y=%0d level=%0d"},
                             $realtime, want.x, want.y, want.level,
                             got.x, got.y, got.level);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [3:0] pixel_x, [7:4] pixel_y, [9:8] level

    pixel_write_board board = new;
    int accepted_bytes = 0;
    int writes_seen = 0;
    int quiet_cycles = 0;

    frame_stream_pixel_mapper_unit #(.MAX_PIXELS(PIXEL_LIMIT)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Both sides run without gaps while the byte count is inside this window.
    function automatic bit take_break();
        if (accepted_bytes >= 800 && accepted_bytes < 1100) return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (take_break()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_byte(b);
        accepted_bytes++;
    endtask

    task automatic send_frame(input logic [7:0] h_lo, input logic [7:0] w_lo, input int pixels);
        foreach (MAGIC_SEQ[i]) push_byte(MAGIC_SEQ[i]);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(h_lo);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(w_lo);
        repeat (4) push_byte(8'($urandom_range(0, 255)));
        repeat (pixels) push_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stalls, plus one long hold-off that backs up the input.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (writes_seen >= 150 && writes_seen < 100000) begin
                writes_seen = 100000 + writes_seen;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            m_axis_tready <= !take_break();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_write(t_pixel_write'({m_axis_tdata[3:0], m_axis_tdata[7:4],
                                              m_axis_tdata[9:8]}));
            writes_seen++;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int pick;
        int h;
        int w;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A broken magic start: the repeated first byte is dropped, not rechecked.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(MAGIC_0);
        push_byte(MAGIC_0);
        push_byte(MAGIC_1);
        push_byte(MAGIC_2);
        push_byte(MAGIC_3);
        // An empty frame, then one too large to keep.
        send_frame(8'h00, 8'h00, 0);
        foreach (MAGIC_SEQ[i]) push_byte(MAGIC_SEQ[i]);
        repeat (4) push_byte(8'hFF);

        while (accepted_bytes < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_frame(WIDE_H, WIDE_W, 144);
            end else if (pick < 50) begin
                send_frame(SQUARE_H, SQUARE_W, 256);
            end else if (pick < 65) begin
                h = $urandom_range(0, 20);
                w = $urandom_range(0, 40);
                send_frame(8'(h), 8'(w), (h * w > PIXEL_LIMIT) ? 0 : h * w);
            end else if (pick < 75) begin
                if ($urandom_range(0, 1))
                    send_frame(WIDE_H, WIDE_W, $urandom_range(1, 143));
                else
                    send_frame(SQUARE_H, SQUARE_W, $urandom_range(1, 255));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 1))
                        push_byte(MAGIC_SEQ[$urandom_range(0, 3)]);
                    else
                        push_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                pick = $urandom_range(1, 3);
                for (int i = 0; i < pick; i++) push_byte(MAGIC_SEQ[i]);
                push_byte(8'($urandom_range(0, 255)));
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_writes.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_writes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
